// ----- rtl/core/dmrg_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual motor ramp package
// Widths, item kind codes, register addresses and the per-channel state type
// shared by the ramp core, its channel lanes and the channel interfaces.
// ----------------------------------------------------------------------------
package dmrg_pkg;

  localparam int DUTY_WIDTH       = 8;
  localparam int TICK_COUNT_WIDTH = 16;
  localparam int STEP_WIDTH       = 8;
  localparam int INTERVAL_WIDTH   = 16;
  localparam int KIND_WIDTH       = 2;

  // Arithmetic width for duty and step: the wider of the two, plus a carry bit.
  localparam int RAMP_CALC_WIDTH =
    ((DUTY_WIDTH > STEP_WIDTH) ? DUTY_WIDTH : STEP_WIDTH) + 1;
  localparam int TICK_CALC_WIDTH =
    (TICK_COUNT_WIDTH > INTERVAL_WIDTH) ? TICK_COUNT_WIDTH : INTERVAL_WIDTH;

  localparam int CFG_ADDR_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;

  typedef logic [KIND_WIDTH-1:0]     kind_t;
  typedef logic [DUTY_WIDTH-1:0]     duty_t;
  typedef logic [STEP_WIDTH-1:0]     step_t;
  typedef logic [INTERVAL_WIDTH-1:0] interval_t;
  typedef logic [TICK_COUNT_WIDTH-1:0] tick_t;

  localparam kind_t KIND_TICK = kind_t'(0);
  localparam kind_t KIND_SET  = kind_t'(1);
  localparam kind_t KIND_STOP = kind_t'(2);

  // Register select is address bit 2: step at 0x0, interval at 0x4.
  localparam logic REG_RAMP_STEP     = 1'b0;
  localparam logic REG_RAMP_INTERVAL = 1'b1;

  localparam step_t     RAMP_STEP_RESET     = step_t'(5);
  localparam interval_t RAMP_INTERVAL_RESET = interval_t'(10);

  localparam tick_t TICK_MAX = {TICK_COUNT_WIDTH{1'b1}};

  // Pin pair order: bit 0 forward, bit 1 reverse.
  localparam logic [1:0] PINS_OFF = 2'b00;
  localparam logic [1:0] PINS_FWD = 2'b01;
  localparam logic [1:0] PINS_REV = 2'b10;

  typedef struct packed {
    duty_t      level;
    logic       dir;
    logic [1:0] pins;
  } ch_state_t;

endpackage

// ----- rtl/core/dmrg_if.sv -----
// ----------------------------------------------------------------------------
// Dual motor ramp channel interfaces
// Valid/ready channels for the command word and the status word.
// ----------------------------------------------------------------------------
interface dmrg_cmd_if
  import dmrg_pkg::*;
  ();
  logic  valid;
  logic  ready;
  kind_t kind;
  logic  dir_left_in;
  logic  dir_right_in;
  duty_t speed_left_in;
  duty_t speed_right_in;

  modport source (output valid, kind, dir_left_in, dir_right_in,
                  speed_left_in, speed_right_in, input ready);
  modport sink   (input valid, kind, dir_left_in, dir_right_in,
                  speed_left_in, speed_right_in, output ready);
endinterface

interface dmrg_status_if
  import dmrg_pkg::*;
  ();
  logic  valid;
  logic  ready;
  duty_t duty_left;
  duty_t duty_right;
  logic  bridge_a_fwd;
  logic  bridge_a_rev;
  logic  bridge_b_fwd;
  logic  bridge_b_rev;
  logic  wanted_dir_left;
  logic  wanted_dir_right;

  modport source (output valid, duty_left, duty_right, bridge_a_fwd, bridge_a_rev,
                  bridge_b_fwd, bridge_b_rev, wanted_dir_left, wanted_dir_right,
                  input ready);
  modport sink   (input valid, duty_left, duty_right, bridge_a_fwd, bridge_a_rev,
                  bridge_b_fwd, bridge_b_rev, wanted_dir_left, wanted_dir_right,
                  output ready);
endinterface

// ----- rtl/core/dmrg_lane.sv -----
// ----------------------------------------------------------------------------
// Dual motor ramp channel lane
// One ramp update for one H-bridge channel: reverse guard, direction pickup
// at zero duty and a step-limited move of the duty toward its goal.
// ----------------------------------------------------------------------------
module dmrg_lane
  import dmrg_pkg::*;
(
  input  ch_state_t cur,
  input  duty_t     goal,
  input  logic      goal_dir,
  input  step_t     step,
  output ch_state_t nxt
);

  logic [RAMP_CALC_WIDTH-1:0] lv_w;
  logic [RAMP_CALC_WIDTH-1:0] goal_w;
  logic [RAMP_CALC_WIDTH-1:0] st_w;
  logic [RAMP_CALC_WIDTH-1:0] up_gap;
  logic [RAMP_CALC_WIDTH-1:0] down_gap;
  logic [RAMP_CALC_WIDTH-1:0] moved;
  logic                       at_zero;

  assign lv_w     = RAMP_CALC_WIDTH'(cur.level);
  assign goal_w   = RAMP_CALC_WIDTH'(goal);
  assign st_w     = RAMP_CALC_WIDTH'(step);
  assign up_gap   = goal_w - lv_w;
  assign down_gap = lv_w - goal_w;
  assign at_zero  = (cur.level == '0);

  always_comb begin
    if (lv_w < goal_w) begin
      moved = (up_gap > st_w) ? lv_w + st_w : goal_w;
    end else if (lv_w > goal_w) begin
      moved = (down_gap > st_w) ? lv_w - st_w : goal_w;
    end else begin
      moved = lv_w;
    end
  end

  always_comb begin
    nxt = cur;
    if ((cur.dir != goal_dir) && !at_zero) begin
      // Wrong direction while moving: only slow down, keep pins as they are.
      nxt.level = (lv_w > st_w) ? duty_t'(lv_w - st_w) : '0;
    end else begin
      if (at_zero) begin
        nxt.dir  = goal_dir;
        nxt.pins = goal_dir ? PINS_FWD : PINS_REV;
      end
      nxt.level = duty_t'(moved);
    end
  end

endmodule

// ----- rtl/core/dual_motor_ramp_reverse_guard.sv -----
// ----------------------------------------------------------------------------
// Dual motor ramp with reverse guard
// Two H-bridge channels with slew-limited duty, guarded direction reversal
// and an immediate stop, driven by tick, set and stop command words.
// ----------------------------------------------------------------------------
// Usage:
//   in_cmd carries one command word per handshake: a millisecond tick, a set
//   of goal directions and duties for both channels, or a stop. Every
//   accepted word yields exactly one status word on out_status, holding the
//   duties, the four bridge pin levels and the goal directions after that
//   command took effect.
//   The status word is in the output register on the cycle after the
//   command is accepted. Throughput is one word per cycle while the receiver
//   takes each word; the two channel lanes evaluate side by side in the
//   cycle of acceptance and the merge stage packs them into the output register.
//   When the receiver stalls, the output register holds its word and
//   in_cmd.ready drops until that word is taken.
//   The APB-style cfg_ port sets the ramp step (0x0) and the ramp interval
//   in ticks (0x4); write it only while the block is idle.
//   Reset clears duties, goals and the tick counter, sets all directions
//   forward, sets the channel pin state off and loads step 5, interval 10.
// ----------------------------------------------------------------------------
module dual_motor_ramp_reverse_guard
  import dmrg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  dmrg_cmd_if.sink                  in_cmd,
  dmrg_status_if.source             out_status,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] cfg_paddr,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_pwdata,
  output logic [CFG_DATA_WIDTH-1:0] cfg_prdata,
  output logic                      cfg_pready
);

  // Configuration registers.
  step_t     ramp_step_r;
  interval_t ramp_interval_r;
  logic      cfg_wr;
  logic      cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r     <= RAMP_STEP_RESET;
      ramp_interval_r <= RAMP_INTERVAL_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_RAMP_STEP:     ramp_step_r     <= cfg_pwdata[STEP_WIDTH-1:0];
        REG_RAMP_INTERVAL: ramp_interval_r <= cfg_pwdata[INTERVAL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_RAMP_STEP:     cfg_prdata = CFG_DATA_WIDTH'(ramp_step_r);
      REG_RAMP_INTERVAL: cfg_prdata = CFG_DATA_WIDTH'(ramp_interval_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // Core state.
  ch_state_t left_r,  left_nxt;
  ch_state_t right_r, right_nxt;
  duty_t     goal_left_r,  goal_left_nxt;
  duty_t     goal_right_r, goal_right_nxt;
  logic      goal_dir_left_r,  goal_dir_left_nxt;
  logic      goal_dir_right_r, goal_dir_right_nxt;
  tick_t     elapsed_r, elapsed_nxt;

  ch_state_t left_ramp;
  ch_state_t right_ramp;
  tick_t     elapsed_inc;
  logic      ramp_due;
  logic      accept;

  dmrg_lane u_lane_left (
    .cur      (left_r),
    .goal     (goal_left_r),
    .goal_dir (goal_dir_left_r),
    .step     (ramp_step_r),
    .nxt      (left_ramp)
  );

  dmrg_lane u_lane_right (
    .cur      (right_r),
    .goal     (goal_right_r),
    .goal_dir (goal_dir_right_r),
    .step     (ramp_step_r),
    .nxt      (right_ramp)
  );

  assign elapsed_inc = (elapsed_r < TICK_MAX) ? elapsed_r + tick_t'(1) : elapsed_r;
  assign ramp_due    = TICK_CALC_WIDTH'(elapsed_inc) >= TICK_CALC_WIDTH'(ramp_interval_r);

  always_comb begin
    left_nxt           = left_r;
    right_nxt          = right_r;
    goal_left_nxt      = goal_left_r;
    goal_right_nxt     = goal_right_r;
    goal_dir_left_nxt  = goal_dir_left_r;
    goal_dir_right_nxt = goal_dir_right_r;
    elapsed_nxt        = elapsed_r;
    unique case (in_cmd.kind)
      KIND_TICK: begin
        if (ramp_due) begin
          elapsed_nxt = '0;
          left_nxt    = left_ramp;
          right_nxt   = right_ramp;
        end else begin
          elapsed_nxt = elapsed_inc;
        end
      end
      KIND_SET: begin
        goal_dir_left_nxt  = in_cmd.dir_left_in;
        goal_dir_right_nxt = in_cmd.dir_right_in;
        goal_left_nxt      = in_cmd.speed_left_in;
        goal_right_nxt     = in_cmd.speed_right_in;
      end
      KIND_STOP: begin
        // A stop leaves the tick counter as it is.
        goal_left_nxt      = '0;
        goal_right_nxt     = '0;
        goal_dir_left_nxt  = 1'b1;
        goal_dir_right_nxt = 1'b1;
        left_nxt           = '{level: '0, dir: 1'b1, pins: PINS_OFF};
        right_nxt          = '{level: '0, dir: 1'b1, pins: PINS_OFF};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r           <= '{level: '0, dir: 1'b1, pins: PINS_OFF};
      right_r          <= '{level: '0, dir: 1'b1, pins: PINS_OFF};
      goal_left_r      <= '0;
      goal_right_r     <= '0;
      goal_dir_left_r  <= 1'b1;
      goal_dir_right_r <= 1'b1;
      elapsed_r        <= '0;
    end else if (accept) begin
      left_r           <= left_nxt;
      right_r          <= right_nxt;
      goal_left_r      <= goal_left_nxt;
      goal_right_r     <= goal_right_nxt;
      goal_dir_left_r  <= goal_dir_left_nxt;
      goal_dir_right_r <= goal_dir_right_nxt;
      elapsed_r        <= elapsed_nxt;
    end
  end

  // Merge stage: both lanes' results packed into the output register.
  logic out_valid_r;
  duty_t duty_left_r, duty_right_r;
  logic [1:0] pins_a_r, pins_b_r;
  logic wanted_left_r, wanted_right_r;

  assign in_cmd.ready = !out_valid_r || out_status.ready;
  assign accept       = in_cmd.valid && in_cmd.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_cmd.ready) begin
      out_valid_r <= in_cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      duty_left_r    <= left_nxt.level;
      duty_right_r   <= right_nxt.level;
      pins_a_r       <= left_nxt.pins;
      pins_b_r       <= right_nxt.pins;
      wanted_left_r  <= goal_dir_left_nxt;
      wanted_right_r <= goal_dir_right_nxt;
    end
  end

  assign out_status.valid            = out_valid_r;
  assign out_status.duty_left        = duty_left_r;
  assign out_status.duty_right       = duty_right_r;
  assign out_status.bridge_a_fwd     = pins_a_r[0];
  assign out_status.bridge_a_rev     = pins_a_r[1];
  assign out_status.bridge_b_fwd     = pins_b_r[0];
  assign out_status.bridge_b_rev     = pins_b_r[1];
  assign out_status.wanted_dir_left  = wanted_left_r;
  assign out_status.wanted_dir_right = wanted_right_r;

endmodule
